FILE: rtl/rfts_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and sizes for the range flow table switch.
// Used by every module in rtl/; depends on nothing.
package rfts_pkg;

  localparam int TABLE_DEPTH  = 16;
  localparam int ADDR_MAX     = 1023;

  localparam int ADDR_W       = 10;
  localparam int SW_W         = 3;
  localparam int MODE_W       = 3;
  localparam int VERDICT_W    = 3;
  localparam int PORT_W       = 2;
  localparam int RULE_INDEX_W = 4;
  localparam int HITS_W       = 32;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;

  localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W        = $clog2(TABLE_DEPTH + 1);

  // input item modes
  localparam logic [MODE_W-1:0] MODE_PACKET   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_FWD  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_DROP = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RELAY    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CONN_ACK = 3'd4;

  // result verdicts
  localparam logic [VERDICT_W-1:0] VERDICT_NONE     = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_LOCAL    = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_RELAY    = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_ASK      = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_DROPPED  = 3'd4;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_CONN = 3'd5;
  localparam logic [VERDICT_W-1:0] VERDICT_FULL     = 3'd6;

  // output ports
  localparam logic [PORT_W-1:0] PORT_NONE   = 2'd0;
  localparam logic [PORT_W-1:0] PORT_REMOTE = 2'd1;
  localparam logic [PORT_W-1:0] PORT_OWN    = 2'd2;
  localparam logic [PORT_W-1:0] PORT_LOCAL  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SWITCH_NUMBER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_LOW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_HIGH    = 2'd2;

  typedef enum logic [1:0] {
    LINK_DISCONNECTED = 2'd0,
    LINK_CONNECTED    = 2'd1,
    LINK_WAITING      = 2'd2
  } link_t;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_DISPATCH = 2'd1,
    ST_SCAN     = 2'd2,
    ST_UPDATE   = 2'd3
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic              drop;
    logic [PORT_W-1:0] port;
  } rule_entry_t;

  // operands of the shared compare / count unit
  typedef struct packed {
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] addr;
    logic [HITS_W-1:0] cnt;
  } alu_req_t;

  typedef struct packed {
    logic              in_range;
    logic [HITS_W-1:0] cnt_inc;
  } alu_resp_t;

  function automatic logic [ADDR_W-1:0] sat_addr(input logic [ADDR_W-1:0] v);
    logic [ADDR_W:0] lim;
    lim = (ADDR_W + 1)'(ADDR_MAX);
    return ({1'b0, v} > lim) ? lim[ADDR_W-1:0] : v;
  endfunction

endpackage

FILE: rtl/range_flow_table_switch.sv
`timescale 1ns / 1ps
// Each item gives one result beat. Packets in the local range, relay, add and ack items
// and packets that need no search go from DISPATCH back to IDLE; a table search reads one
// rule per cycle in SCAN from rule 0 through the single compare unit and goes to UPDATE
// on a match, or back to IDLE after the last rule. start is taken again in the strobe
// cycle. Reset (rst_n low, synchronous) empties the table and disconnects the link;
// rule entries are not cleared. Results cannot be stalled.
module range_flow_table_switch (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rfts_pkg::MODE_W-1:0]         in_mode,
  input  logic [rfts_pkg::ADDR_W-1:0]         in_dest_addr,
  input  logic [rfts_pkg::ADDR_W-1:0]         in_range_low,
  input  logic [rfts_pkg::ADDR_W-1:0]         in_range_high,
  input  logic [rfts_pkg::SW_W-1:0]           in_next_switch,
  output logic                                out_valid,
  output logic [rfts_pkg::VERDICT_W-1:0]      out_verdict,
  output logic [rfts_pkg::PORT_W-1:0]         out_port,
  output logic [rfts_pkg::ADDR_W-1:0]         out_ask_addr,
  output logic [rfts_pkg::RULE_INDEX_W-1:0]   out_rule_index,
  output logic [rfts_pkg::HITS_W-1:0]         out_hit_count,
  input  logic                                cfg_we,
  input  logic [rfts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rfts_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rfts_pkg::*;

  state_t state_r, state_nxt;
  link_t  link_r, link_nxt;

  logic [MODE_W-1:0] mode_r;
  logic [ADDR_W-1:0] addr_r, rlo_r, rhi_r;
  logic [SW_W-1:0]   nsw_r;

  logic [SW_W-1:0]   switch_number_r;
  logic [ADDR_W-1:0] local_low_r, local_high_r;

  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [CNT_W-1:0]  rules_used_r, rules_used_nxt;
  logic [HITS_W-1:0] local_hits_r, local_hits_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [VERDICT_W-1:0]    verdict_r, verdict_nxt;
  logic [PORT_W-1:0]       port_r, port_nxt;
  logic [ADDR_W-1:0]       ask_r, ask_nxt;
  logic [RULE_INDEX_W-1:0] ridx_r, ridx_nxt;
  logic [HITS_W-1:0]       hits_out_r, hits_out_nxt;

  // rule table
  rule_entry_t       ent_mem [TABLE_DEPTH];
  logic [HITS_W-1:0] hits_mem [TABLE_DEPTH];
  rule_entry_t       ent_q, ent_wdata;
  logic [HITS_W-1:0] hits_q, hits_wdata;
  logic              ent_we, hits_we, rd_en;
  logic [IDX_W-1:0]  wr_idx, rd_idx;

  alu_req_t  alu_req;
  alu_resp_t alu_resp;

  logic              accept;
  logic              table_full;
  logic              last_rule;
  logic [PORT_W-1:0] fwd_port;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign table_full = (rules_used_r >= CNT_W'(TABLE_DEPTH));
  assign last_rule  = ((CNT_W'(scan_r) + CNT_W'(1)) == rules_used_r);
  assign fwd_port   = (nsw_r == switch_number_r) ? PORT_OWN : PORT_REMOTE;

  rfts_alu u_alu (
    .req  (alu_req),
    .resp (alu_resp)
  );

  // operand select for the shared unit
  always_comb begin
    alu_req.addr = addr_r;
    alu_req.lo   = local_low_r;
    alu_req.hi   = local_high_r;
    alu_req.cnt  = local_hits_r;
    if (state_r == ST_SCAN || state_r == ST_UPDATE) begin
      alu_req.lo  = ent_q.lo;
      alu_req.hi  = ent_q.hi;
      alu_req.cnt = hits_q;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_nxt = ST_IDLE;
        if (mode_r == MODE_PACKET && link_r == LINK_CONNECTED &&
            !alu_resp.in_range && rules_used_r != '0) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (alu_resp.in_range) state_nxt = ST_UPDATE;
        else if (last_rule)    state_nxt = ST_IDLE;
      end
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    link_nxt       = link_r;
    scan_nxt       = scan_r;
    rules_used_nxt = rules_used_r;
    local_hits_nxt = local_hits_r;
    out_valid_nxt  = 1'b0;
    verdict_nxt    = verdict_r;
    port_nxt       = port_r;
    ask_nxt        = ask_r;
    ridx_nxt       = ridx_r;
    hits_out_nxt   = hits_out_r;
    ent_we         = 1'b0;
    hits_we        = 1'b0;
    rd_en          = 1'b0;
    rd_idx         = scan_r;
    wr_idx         = rules_used_r[IDX_W-1:0];
    ent_wdata      = '{lo: rlo_r, hi: rhi_r, drop: 1'b0, port: fwd_port};
    hits_wdata     = HITS_W'(1);

    case (state_r)
      ST_DISPATCH: begin
        out_valid_nxt = 1'b1;
        verdict_nxt   = VERDICT_NONE;
        port_nxt      = PORT_NONE;
        ask_nxt       = '0;
        ridx_nxt      = '0;
        hits_out_nxt  = '0;
        case (mode_r)
          MODE_PACKET: begin
            if (link_r != LINK_CONNECTED) begin
              verdict_nxt = VERDICT_NOT_CONN;
            end else if (alu_resp.in_range) begin
              local_hits_nxt = alu_resp.cnt_inc;
              verdict_nxt    = VERDICT_LOCAL;
              port_nxt       = PORT_LOCAL;
              hits_out_nxt   = alu_resp.cnt_inc;
            end else if (rules_used_r == '0) begin
              link_nxt    = LINK_WAITING;
              verdict_nxt = VERDICT_ASK;
              ask_nxt     = addr_r;
            end else begin
              // start the search at rule 0, hold the result
              out_valid_nxt = 1'b0;
              scan_nxt      = '0;
              rd_idx        = '0;
              rd_en         = 1'b1;
            end
          end
          MODE_ADD_FWD, MODE_ADD_DROP: begin
            link_nxt = LINK_CONNECTED;
            if (table_full) begin
              verdict_nxt = VERDICT_FULL;
            end else begin
              if (mode_r == MODE_ADD_DROP) begin
                ent_wdata   = '{lo: addr_r, hi: addr_r, drop: 1'b1, port: PORT_NONE};
                verdict_nxt = VERDICT_DROPPED;
              end else begin
                verdict_nxt = VERDICT_RELAY;
                port_nxt    = fwd_port;
              end
              ent_we         = 1'b1;
              hits_we        = 1'b1;
              rules_used_nxt = rules_used_r + CNT_W'(1);
              ridx_nxt       = RULE_INDEX_W'(rules_used_r);
              hits_out_nxt   = HITS_W'(1);
            end
          end
          MODE_RELAY: begin
            local_hits_nxt = alu_resp.cnt_inc;
            hits_out_nxt   = alu_resp.cnt_inc;
          end
          MODE_CONN_ACK: link_nxt = LINK_CONNECTED;
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (!alu_resp.in_range) begin
          if (last_rule) begin
            // no rule covers it: ask the controller
            link_nxt      = LINK_WAITING;
            out_valid_nxt = 1'b1;
            verdict_nxt   = VERDICT_ASK;
            port_nxt      = PORT_NONE;
            ask_nxt       = addr_r;
            ridx_nxt      = '0;
            hits_out_nxt  = '0;
          end else begin
            scan_nxt = scan_r + IDX_W'(1);
            rd_idx   = scan_r + IDX_W'(1);
            rd_en    = 1'b1;
          end
        end
      end
      ST_UPDATE: begin
        wr_idx        = scan_r;
        hits_wdata    = alu_resp.cnt_inc;
        hits_we       = 1'b1;
        out_valid_nxt = 1'b1;
        verdict_nxt   = ent_q.drop ? VERDICT_DROPPED : VERDICT_RELAY;
        port_nxt      = ent_q.drop ? PORT_NONE : ent_q.port;
        ask_nxt       = '0;
        ridx_nxt      = RULE_INDEX_W'(scan_r);
        hits_out_nxt  = alu_resp.cnt_inc;
      end
      default: ;
    endcase
  end

  // rule table storage
  always_ff @(posedge clk) begin
    if (ent_we)  ent_mem[wr_idx]  <= ent_wdata;
    if (hits_we) hits_mem[wr_idx] <= hits_wdata;
    if (rd_en) begin
      ent_q  <= ent_mem[rd_idx];
      hits_q <= hits_mem[rd_idx];
    end
  end

  // item capture and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      addr_r <= sat_addr(in_dest_addr);
      rlo_r  <= sat_addr(in_range_low);
      rhi_r  <= sat_addr(in_range_high);
      nsw_r  <= in_next_switch;
    end
    scan_r     <= scan_nxt;
    verdict_r  <= verdict_nxt;
    port_r     <= port_nxt;
    ask_r      <= ask_nxt;
    ridx_r     <= ridx_nxt;
    hits_out_r <= hits_out_nxt;
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      link_r          <= LINK_DISCONNECTED;
      rules_used_r    <= '0;
      local_hits_r    <= '0;
      out_valid_r     <= 1'b0;
      switch_number_r <= SW_W'(1);
      local_low_r     <= '0;
      local_high_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      link_r       <= link_nxt;
      rules_used_r <= rules_used_nxt;
      local_hits_r <= local_hits_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SWITCH_NUMBER: switch_number_r <= cfg_data[SW_W-1:0];
          CFG_LOCAL_LOW:     local_low_r     <= sat_addr(cfg_data[ADDR_W-1:0]);
          CFG_LOCAL_HIGH:    local_high_r    <= sat_addr(cfg_data[ADDR_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_verdict    = verdict_r;
  assign out_port       = port_r;
  assign out_ask_addr   = ask_r;
  assign out_rule_index = ridx_r;
  assign out_hit_count  = hits_out_r;

endmodule

FILE: rtl/rfts_alu.sv
`timescale 1ns / 1ps
// Shared range compare and saturating hit counter increment.
// Depends on rfts_pkg.
module rfts_alu (
  input  rfts_pkg::alu_req_t  req,
  output rfts_pkg::alu_resp_t resp
);
  import rfts_pkg::*;

  always_comb begin
    resp.in_range = (req.lo <= req.addr) && (req.addr <= req.hi);
    // saturate at all ones
    resp.cnt_inc  = (&req.cnt) ? req.cnt : req.cnt + HITS_W'(1);
  end

endmodule

FILE: rtl/rfts_checker.sv
`timescale 1ns / 1ps
// Port-level checks for range_flow_table_switch, attached by bind.
// Depends on rfts_pkg.
module rfts_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic [rfts_pkg::VERDICT_W-1:0]      out_verdict,
  input logic [rfts_pkg::RULE_INDEX_W-1:0]   out_rule_index,
  input logic [rfts_pkg::HITS_W-1:0]         out_hit_count
);
  import rfts_pkg::*;

  // a taken start always occupies the block
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("start beat taken but block not busy");

  // every item ends with exactly one result beat
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("item finished without a result beat");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result beat while block busy");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_ask_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_verdict == VERDICT_ASK |-> out_rule_index == '0 && out_hit_count == '0)
    else $error("ask beat carries rule fields");

endmodule

bind range_flow_table_switch rfts_checker u_rfts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_verdict    (out_verdict),
  .out_rule_index (out_rule_index),
  .out_hit_count  (out_hit_count)
);
